[rtl/cck_pkg.sv]
// Shared types and constants for the ChaCha20 keystream generator.
// No dependencies; imported by the controller, datapath and top level.
package cck_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned RoundSteps = 80;   // 20 rounds, 4 add/xor/rotate steps each
  localparam int unsigned AddrW      = 6;
  localparam int unsigned DataW      = 64;

  localparam logic [6:0] PosEmpty = 7'(BlockBytes);
  localparam logic [6:0] LastStep = 7'(RoundSteps - 1);

  localparam logic [31:0] Sigma [4] = '{32'h61707865, 32'h3320646e,
                                        32'h79622d32, 32'h6b206574};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_ROUND,
    ST_FINAL
  } state_e;

  typedef enum logic [2:0] {
    REG_KEY01,
    REG_KEY23,
    REG_KEY45,
    REG_KEY67,
    REG_NONCE_LO,
    REG_NONCE_HI,
    REG_START_CTR
  } reg_idx_e;

  typedef struct packed {
    logic       load;     // copy input state into the working state
    logic       step;     // one quarter-round step on all four lanes
    logic       finish;   // feed-forward add, counter increment
    logic       emit;     // load output register from the buffer
    logic       diag;     // diagonal round
    logic [1:0] phase;
    logic [5:0] pos;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic cfg_wr;
  } dp_status_t;

endpackage

[rtl/cck_ctrl.sv]
// Sequencer for the keystream generator: request intake, block generation
// and byte emission. Depends on cck_pkg.
module cck_ctrl import cck_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [6:0] byte_count_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  state_e     state_q, state_d;
  logic [6:0] pos_q, pos_d;
  logic [6:0] rem_q, rem_d;
  logic [6:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    rem_d       = rem_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    cmd_o        = '0;
    cmd_o.pos    = pos_q[5:0];
    cmd_o.last   = (rem_q == 7'd1);
    cmd_o.phase  = step_q[1:0];
    cmd_o.diag   = step_q[2];

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          rem_d = (byte_count_i > PosEmpty) ? PosEmpty : byte_count_i;
          if (byte_count_i != 7'd0) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (pos_q[6]) begin
          // buffer used up: make a fresh block first
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = ST_ROUND;
        end else if (slot_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          pos_d       = pos_q + 7'd1;
          rem_d       = rem_q - 7'd1;
          if (rem_q == 7'd1) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ROUND: begin
        cmd_o.step = 1'b1;
        step_d     = step_q + 7'd1;
        if (step_q == LastStep) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        cmd_o.finish = 1'b1;
        pos_d        = '0;
        state_d      = ST_EMIT;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (status_i.cfg_wr) begin
      pos_d = PosEmpty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= PosEmpty;
      rem_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      rem_q       <= rem_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/cck_datapath.sv]
// Datapath: configuration registers, block counter, ChaCha working state
// with four quarter-round lanes, keystream buffer and output register.
// Depends on cck_pkg.
module cck_datapath import cck_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output logic [7:0]       keystream_byte_o,
  output logic             last_o,
  input  dp_cmd_t          cmd_i,
  output dp_status_t       status_o
);

  logic [63:0] key_q [4];
  logic [63:0] nonce_lo_q;
  logic [31:0] nonce_hi_q;
  logic [31:0] start_ctr_q;
  logic [31:0] ctr_q;
  logic [31:0] carry_q;

  logic [31:0] init_w [4][4];
  logic [31:0] work_q [4][4];
  logic [31:0] work_d [4][4];
  logic [31:0] ks_buf_q [16];
  logic [31:0] sel_w;
  logic [7:0]  out_byte_q;
  logic        out_last_q;

  logic        wr_en;
  reg_idx_e    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[5:3]);

  always_comb begin
    status_o.cfg_wr = 1'b0;
    prdata          = '0;
    unique case (reg_idx)
      REG_KEY01:     prdata = key_q[0];
      REG_KEY23:     prdata = key_q[1];
      REG_KEY45:     prdata = key_q[2];
      REG_KEY67:     prdata = key_q[3];
      REG_NONCE_LO:  prdata = nonce_lo_q;
      REG_NONCE_HI:  prdata = {32'd0, nonce_hi_q};
      REG_START_CTR: prdata = {32'd0, start_ctr_q};
      default:       prdata = '0;
    endcase
    unique case (reg_idx) inside
      REG_KEY01, REG_KEY23, REG_KEY45, REG_KEY67,
      REG_NONCE_LO, REG_NONCE_HI, REG_START_CTR: status_o.cfg_wr = wr_en;
      default:                                    status_o.cfg_wr = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        key_q[i] <= '0;
      end
      nonce_lo_q  <= '0;
      nonce_hi_q  <= '0;
      start_ctr_q <= '0;
      ctr_q       <= '0;
      carry_q     <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_KEY01: key_q[0] <= pwdata;
        REG_KEY23: key_q[1] <= pwdata;
        REG_KEY45: key_q[2] <= pwdata;
        REG_KEY67: key_q[3] <= pwdata;
        REG_NONCE_LO: begin
          nonce_lo_q <= pwdata;
          carry_q    <= pwdata[31:0];
        end
        REG_NONCE_HI: nonce_hi_q <= pwdata[31:0];
        REG_START_CTR: begin
          start_ctr_q <= pwdata[31:0];
          ctr_q       <= pwdata[31:0];
        end
        default: ;
      endcase
    end else if (cmd_i.finish) begin
      ctr_q <= ctr_q + 32'd1;
      if (ctr_q == '1) begin
        carry_q <= carry_q + 32'd1;
      end
    end
  end

  // RFC 8439 input state, one row of four words per line
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      init_w[0][c] = Sigma[c];
    end
    init_w[1][0] = key_q[0][31:0];
    init_w[1][1] = key_q[0][63:32];
    init_w[1][2] = key_q[1][31:0];
    init_w[1][3] = key_q[1][63:32];
    init_w[2][0] = key_q[2][31:0];
    init_w[2][1] = key_q[2][63:32];
    init_w[2][2] = key_q[3][31:0];
    init_w[2][3] = key_q[3][63:32];
    init_w[3][0] = ctr_q;
    init_w[3][1] = carry_q;
    init_w[3][2] = nonce_lo_q[63:32];
    init_w[3][3] = nonce_hi_q;
  end

  // Four lanes; each step does one add, xor and rotate of the quarter round.
  // Even phases update a and d, odd phases c and b.
  always_comb begin
    logic [1:0]  bi, ci, di;
    logic [31:0] x, y, z, zr;
    work_d = work_q;
    for (int j = 0; j < 4; j++) begin
      bi = cmd_i.diag ? 2'(j + 1) : 2'(j);
      ci = cmd_i.diag ? 2'(j + 2) : 2'(j);
      di = cmd_i.diag ? 2'(j + 3) : 2'(j);
      if (!cmd_i.phase[0]) begin
        x = work_q[0][j];
        y = work_q[1][bi];
        z = work_q[3][di];
      end else begin
        x = work_q[2][ci];
        y = work_q[3][di];
        z = work_q[1][bi];
      end
      x = x + y;
      z = z ^ x;
      case (cmd_i.phase)
        2'd0:    zr = {z[15:0], z[31:16]};
        2'd1:    zr = {z[19:0], z[31:20]};
        2'd2:    zr = {z[23:0], z[31:24]};
        default: zr = {z[24:0], z[31:25]};
      endcase
      if (!cmd_i.phase[0]) begin
        work_d[0][j]  = x;
        work_d[3][di] = zr;
      end else begin
        work_d[2][ci] = x;
        work_d[1][bi] = zr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      work_q <= init_w;
    end else if (cmd_i.step) begin
      work_q <= work_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          ks_buf_q[4'(r * 4 + c)] <= work_q[r][c] + init_w[r][c];
        end
      end
    end
  end

  assign sel_w = ks_buf_q[cmd_i.pos[5:2]];

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q <= sel_w[{cmd_i.pos[1:0], 3'b000} +: 8];
      out_last_q <= cmd_i.last;
    end
  end

  assign keystream_byte_o = out_byte_q;
  assign last_o           = out_last_q;

endmodule

[rtl/chacha20_keystream_generator_core.sv]
// ChaCha20 keystream generator, top level.
// Uses cck_pkg, cck_ctrl and cck_datapath.
//
// Usage: program key, nonce and start counter over the APB port (64-bit
// registers at byte addresses 8*i), then send requests of 1 to 64 bytes on
// the in_valid_i/in_ready_o channel (larger counts are capped at 64, zero is
// dropped). Bytes come out one per out_valid_o/out_ready_i transfer, the
// last one of each request flagged by last_o.
// Flow: a request served from the current block moves the sequencer into its
// emit state, which loads the first byte into the output register; further
// bytes follow one per cycle while the receiver takes them. When the 64-byte
// buffer runs dry, the sequencer first loads the working state, runs the 20
// rounds (one add/xor/rotate step of four quarter-round lanes per cycle) and
// then does the feed-forward add. One request is served at a time; the next
// is taken once the previous one's last byte sits in the output register.
// Reset clears configuration to zero and marks the buffer empty. Any
// register write also empties it. A stalled receiver holds the output
// register and the sequencer waits; nothing is lost.
module chacha20_keystream_generator_core import cck_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [6:0]       byte_count_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       keystream_byte_o,
  output logic             last_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  dp_cmd_t    cmd;
  dp_status_t status;

  cck_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_count_i (byte_count_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_o        (cmd),
    .status_i     (status)
  );

  cck_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .keystream_byte_o (keystream_byte_o),
    .last_o           (last_o),
    .cmd_i            (cmd),
    .status_o         (status)
  );

endmodule

[rtl/cck_sva.sv]
// Port-level checks for the keystream generator, bound to the top level.
// No package dependency.
module cck_sva (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [6:0] byte_count_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] keystream_byte_o,
  input logic       last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(keystream_byte_o) && $stable(last_o))
    else $error("stalled output changed");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (byte_count_i != 7'd0) |=> !in_ready_o)
    else $error("request taken while another is in service");

  a_zero_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (byte_count_i == 7'd0) |=> in_ready_o)
    else $error("zero-byte request started service");

  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i))
    else $error("input ready dropped without a request");

endmodule

bind chacha20_keystream_generator_core cck_sva u_sva (.*);
